// ===== rtl/gdd_pkg.sv =====
// Shared widths, constants and types for the Gregorian date difference block.
package gdd_pkg;

  localparam int DAY_W    = 5;
  localparam int MON_W    = 4;
  localparam int YEAR_W   = 14;
  localparam int DIFF_W   = 23;
  localparam int SERIAL_W = 23;
  localparam int KEY_W    = YEAR_W + MON_W + DAY_W;
  localparam int QUO_W    = 8;   // floor(16383 / 100) fits in 8 bits
  localparam int MSTART_W = 9;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 43699
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + 13;

  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY       = 100;
  localparam int DIFF_LIMIT    = 3652058;

  localparam logic [MSTART_W-1:0] MONTH_START [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  // Per-stage advance strobes of the shared pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    logic [KEY_W-1:0]    key;
  } lane_out_t;

endpackage

// ===== rtl/gdd_lane.sv =====
// One date lane: turns day, month and year into a serial day count.
module gdd_lane
  import gdd_pkg::*;
(
  input  logic              clk,
  input  pipe_en_t          en,
  input  logic [DAY_W-1:0]  day,
  input  logic [MON_W-1:0]  month,
  input  logic [YEAR_W-1:0] year,
  output lane_out_t         result
);

  // stage 1: constant multiplies
  logic [SERIAL_W-1:0] n365;
  logic [QUO_W-1:0]    qn;
  logic [QUO_W-1:0]    qy;
  logic [YEAR_W-3:0]   nq4;
  logic [YEAR_W-1:0]   yr;
  logic [MON_W-1:0]    mon;
  logic [DAY_W-1:0]    dy;

  logic [YEAR_W-1:0] n;
  logic [PROD_W-1:0] prod_n;
  logic [PROD_W-1:0] prod_y;

  always_comb begin
    n      = (year == '0) ? '0 : year - YEAR_W'(1);
    prod_n = PROD_W'(n) * PROD_W'(RECIP_100);
    prod_y = PROD_W'(year) * PROD_W'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      n365 <= SERIAL_W'(n) * SERIAL_W'(DAYS_PER_YEAR);
      qn   <= prod_n[RECIP_SHIFT +: QUO_W];
      qy   <= prod_y[RECIP_SHIFT +: QUO_W];
      nq4  <= n[YEAR_W-1:2];
      yr   <= year;
      mon  <= month;
      dy   <= day;
    end
  end

  // stage 2: leap rule and final sum
  logic [YEAR_W:0]     cent;
  logic                div100;
  logic                leap;
  logic [SERIAL_W-1:0] total;

  always_comb begin
    cent   = (YEAR_W+1)'(qy) * (YEAR_W+1)'(CENTURY);
    div100 = (cent == {1'b0, yr});
    leap   = ((yr[1:0] == 2'b00) && !div100) || (div100 && (qy[1:0] == 2'b00));
    total  = n365 + SERIAL_W'(nq4) - SERIAL_W'(qn) + SERIAL_W'(qn >> 2)
           + SERIAL_W'(MONTH_START[mon])
           + SERIAL_W'(leap && (mon >= MON_W'(3)))
           + SERIAL_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      result.serial <= total;
      result.key    <= {yr, mon, dy};   // packed order matches year/month/day order
    end
  end

endmodule

// ===== rtl/gdd_merge.sv =====
// Merge stage: saturated difference and order compare of the two lanes.
module gdd_merge
  import gdd_pkg::*;
(
  input  logic                     clk,
  input  pipe_en_t                 en,
  input  lane_out_t                lane_a,
  input  lane_out_t                lane_b,
  output logic signed [DIFF_W-1:0] diff_days,
  output logic                     a_before_b,
  output logic                     a_equals_b
);

  localparam logic signed [SERIAL_W:0] LIM_POS = (SERIAL_W+1)'(DIFF_LIMIT);
  localparam logic signed [SERIAL_W:0] LIM_NEG = -LIM_POS;

  logic signed [SERIAL_W:0] raw;
  logic signed [SERIAL_W:0] clamped;

  always_comb begin
    raw = $signed({1'b0, lane_a.serial}) - $signed({1'b0, lane_b.serial});
    if (raw > LIM_POS) begin
      clamped = LIM_POS;
    end else if (raw < LIM_NEG) begin
      clamped = LIM_NEG;
    end else begin
      clamped = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      diff_days  <= clamped[DIFF_W-1:0];
      a_before_b <= lane_a.key < lane_b.key;
      a_equals_b <= lane_a.key == lane_b.key;
    end
  end

endmodule

// ===== rtl/gregorian_date_difference.sv =====
// An accepted item passes through stage 1, stage 2 and the stage 3 output register.
// Throughput: one item per cycle unless out_ready stalls; two date lanes run side by side, merged in stage 3.
// Each stage advances whenever its successor is empty or moving, so input is
// taken while a result waits unless all three stages hold items.
// Reset (synchronous, active high) clears the stage valid bits; data regs are not reset.
// No state is kept between items.
module gregorian_date_difference
  import gdd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DAY_W-1:0]         day_a,
  input  logic [MON_W-1:0]         month_a,
  input  logic [YEAR_W-1:0]        year_a,
  input  logic [DAY_W-1:0]         day_b,
  input  logic [MON_W-1:0]         month_b,
  input  logic [YEAR_W-1:0]        year_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DIFF_W-1:0] diff_days,
  output logic                     a_before_b,
  output logic                     a_equals_b
);

  logic      v1;
  logic      v2;
  logic      v3;
  pipe_en_t  en;
  lane_out_t lane_a;
  lane_out_t lane_b;

  always_comb begin
    en.s3 = !v3 || out_ready;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign in_ready  = en.s1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
    end
  end

  gdd_lane u_lane_a (
    .clk    (clk),
    .en     (en),
    .day    (day_a),
    .month  (month_a),
    .year   (year_a),
    .result (lane_a)
  );

  gdd_lane u_lane_b (
    .clk    (clk),
    .en     (en),
    .day    (day_b),
    .month  (month_b),
    .year   (year_b),
    .result (lane_b)
  );

  gdd_merge u_merge (
    .clk        (clk),
    .en         (en),
    .lane_a     (lane_a),
    .lane_b     (lane_b),
    .diff_days  (diff_days),
    .a_before_b (a_before_b),
    .a_equals_b (a_equals_b)
  );

  // input only blocks when every stage is full and the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && !out_ready))
    else $error("input stalled with room in pipeline");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted item lost at stage 1");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && a_equals_b) |-> (diff_days == '0 && !a_before_b))
    else $error("equal dates with nonzero difference or ordering");

endmodule
